FILE: hw/rtl/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// Shared constants and types for the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;
    localparam int CAPACITY_DEF = 16;

    localparam logic [3:0] F_ADD_BACK   = 4'd0;
    localparam logic [3:0] F_ADD_FRONT  = 4'd1;
    localparam logic [3:0] F_INSERT     = 4'd2;
    localparam logic [3:0] F_REM_BACK   = 4'd3;
    localparam logic [3:0] F_REM_FRONT  = 4'd4;
    localparam logic [3:0] F_REM_AT     = 4'd5;
    localparam logic [3:0] F_CONTAINS   = 4'd6;
    localparam logic [3:0] F_GET        = 4'd7;
    localparam logic [3:0] F_FIND       = 4'd8;
    localparam logic [3:0] F_LENGTH     = 4'd9;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [3:0]         func;
        logic signed [31:0] item_value;
        logic [7:0]         position_in;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data_out;
        logic [4:0]         position_out;
        logic [4:0]         length_out;
    } t_res;
endpackage

FILE: hw/rtl/ole_if.sv
// ----------------------------------------------------------------------------
// ole_cmd_if / ole_res_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface ole_cmd_if;
    import ole_pkg::*;
    logic valid;
    logic ready;
    t_cmd payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ole_res_if;
    import ole_pkg::*;
    logic valid;
    logic ready;
    t_res payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/ordered_list_engine_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_unit
// Bounded ordered list of signed 32-bit values held in one memory.
// ----------------------------------------------------------------------------
// Commands arrive on i_cmd and each gives exactly one result on o_res.
// Both channels transfer when valid and ready are high at a clock edge.
// Length, contains or find on an empty list and the error cases go from
// S_IDLE straight to S_DONE; get first reads its entry in S_RDGET. An
// insert moves each entry behind its position with a read and then a
// write; a remove fetches the removed entry in S_RDGET and then overlaps
// its reads with its writes. Contains and find scan one entry per cycle
// until a hit or the end of the list. The memory port has a registered
// read.
// One command is in flight at a time. A finished result waits in an output
// register while the receiver stalls, and no new command is accepted until
// that result is taken, at the earliest in the same cycle.
// Reset (synchronous, active low) empties the list at once; the memory
// itself is not cleared, as entries at or beyond the length are never read.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit #(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ole_cmd_if.sink   i_cmd,
    ole_res_if.source o_res
);
    import ole_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    // Wide enough for both the full 8-bit position and the count.
    localparam int XW = (CW + 1 > 9) ? CW + 1 : 9;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRD   = 3'd1;  // shift: read
    localparam logic [2:0] S_SWR   = 3'd2;  // shift: write
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_RDGET = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] r_rdata;
    logic               mem_we;
    logic [AW-1:0]      mem_wa, mem_ra;
    logic signed [31:0] mem_wd;

    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_ptr, n_ptr;     // shift or scan cursor
    logic [CW-1:0]      r_stop, n_stop;
    logic               r_dir, n_dir;     // 1 opens a gap, 0 closes one
    logic [3:0]         r_func, n_func;
    logic signed [31:0] r_val, n_val;
    logic               r_scan_v, n_scan_v;
    t_res               r_res, n_res;
    t_res               r_pend, n_pend;
    logic               r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rdata <= mem[mem_ra];
    end

    logic [XW-1:0] pos_ext;
    assign pos_ext = XW'(i_cmd.payload.position_in);

    assign i_cmd.ready = (r_state == S_IDLE) && !(r_ovalid && !o_res.ready);
    assign o_res.valid = r_ovalid;
    assign o_res.payload = r_res;

    function automatic logic [4:0] cnt5(input logic [CW-1:0] c);
        logic [CW+4:0] w;
        w = {5'd0, c};
        return w[4:0];
    endfunction

    always_comb begin
        logic [XW-1:0] at;
        logic [XW-1:0] cnt;
        n_state = r_state; n_count = r_count; n_ptr = r_ptr; n_stop = r_stop;
        n_dir = r_dir; n_func = r_func; n_val = r_val; n_scan_v = 1'b0;
        n_res = r_res; n_pend = r_pend; n_ovalid = r_ovalid;
        mem_we = 1'b0; mem_wa = '0; mem_wd = r_val; mem_ra = r_ptr[AW-1:0];
        cnt = XW'(r_count);
        at = '0;
        if (r_ovalid && o_res.ready) n_ovalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid && i_cmd.ready) begin
                    n_func = i_cmd.payload.func;
                    n_val = i_cmd.payload.item_value;
                    n_pend = '{ST_OK, 32'sd0, 5'd0, cnt5(r_count)};
                    n_state = S_DONE;
                    case (i_cmd.payload.func)
                        F_ADD_BACK, F_ADD_FRONT, F_INSERT: begin
                            at = (i_cmd.payload.func == F_ADD_BACK) ? cnt :
                                 (i_cmd.payload.func == F_ADD_FRONT) ? '0 : pos_ext;
                            if (at > cnt) n_pend.status = ST_MISS;
                            else if (cnt >= CAPACITY) n_pend.status = ST_FULL;
                            else begin
                                n_dir = 1'b1; n_ptr = r_count;
                                n_stop = at[CW-1:0];
                                n_count = r_count + 1'b1;
                                n_pend.length_out = cnt5(n_count);
                                n_state = S_SRD;
                            end
                        end
                        F_REM_BACK, F_REM_FRONT, F_REM_AT: begin
                            at = (i_cmd.payload.func == F_REM_BACK) ? cnt - 1'b1 :
                                 (i_cmd.payload.func == F_REM_FRONT) ? '0 : pos_ext;
                            if (cnt == 0 || at >= cnt) n_pend.status = ST_MISS;
                            else begin
                                // Fetch the removed entry first, then close the gap.
                                n_dir = 1'b0; n_ptr = at[CW-1:0];
                                n_stop = r_count - 1'b1;
                                n_count = r_count - 1'b1;
                                n_pend.length_out = cnt5(n_count);
                                mem_ra = at[AW-1:0];
                                n_state = S_RDGET;
                            end
                        end
                        F_GET: begin
                            if (pos_ext < cnt) begin
                                mem_ra = pos_ext[AW-1:0];
                                n_state = S_RDGET;
                            end else n_pend.status = ST_MISS;
                        end
                        F_CONTAINS, F_FIND: begin
                            n_ptr = '0;
                            if (r_count == 0) n_pend.status = ST_MISS;
                            else begin
                                mem_ra = '0; n_scan_v = 1'b1;
                                n_ptr = {{(CW-1){1'b0}}, 1'b1};
                                n_state = S_SCAN;
                            end
                        end
                        F_LENGTH: n_pend.position_out = cnt5(r_count);
                        default: n_pend.status = ST_MISS;
                    endcase
                end
            end
            S_RDGET: begin
                n_pend.data_out = r_rdata;
                if (r_func == F_GET) n_state = S_DONE;
                else if (r_ptr == r_stop) n_state = S_DONE;
                else begin
                    mem_ra = AW'(r_ptr + 1'b1);
                    n_state = S_SWR;
                end
            end
            S_SRD: begin
                if (r_ptr == r_stop) begin
                    mem_we = 1'b1; mem_wa = r_ptr[AW-1:0]; mem_wd = r_val;
                    n_state = S_DONE;
                end else begin
                    mem_ra = AW'(r_ptr - 1'b1);
                    n_state = S_SWR;
                end
            end
            S_SWR: begin
                mem_we = 1'b1; mem_wa = r_ptr[AW-1:0]; mem_wd = r_rdata;
                if (r_dir) begin
                    n_ptr = r_ptr - 1'b1;
                    n_state = S_SRD;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                    if (n_ptr == r_stop) n_state = S_DONE;
                    else begin
                        mem_ra = AW'(n_ptr + 1'b1);
                        n_state = S_SWR;
                    end
                end
            end
            S_SCAN: begin
                // r_rdata holds entry r_ptr - 1.
                if (r_scan_v && r_rdata == r_val) begin
                    if (r_func == F_FIND) n_pend.position_out = cnt5(r_ptr - 1'b1);
                    n_state = S_DONE;
                end else if (r_scan_v && r_ptr == r_count) begin
                    n_pend.status = ST_MISS;
                    n_state = S_DONE;
                end else begin
                    mem_ra = r_ptr[AW-1:0];
                    n_ptr = r_ptr + 1'b1;
                    n_scan_v = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_ovalid || o_res.ready) begin
                    n_res = r_pend; n_ovalid = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_ovalid <= 1'b0; r_scan_v <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_ovalid <= n_ovalid;
            r_scan_v <= n_scan_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr; r_stop <= n_stop; r_dir <= n_dir; r_func <= n_func;
        r_val <= n_val; r_res <= n_res; r_pend <= n_pend;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAPACITY) else $error("entry count beyond capacity");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_res.ready |=> r_ovalid && $stable(r_res))
        else $error("stalled result changed");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !i_cmd.ready) else $error("command taken while busy");
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> {1'b0, mem_wa} < (AW+1)'(r_count))
        else $error("write beyond the list");
endmodule
